FILE: rtl/modbus_rtu_reply_checker_macros.svh
// assertion macros for the modbus rtu reply checker
// used by every rtl file that carries concurrent checks; needs clk_i and rst_ni in scope
`ifndef MODBUS_RTU_REPLY_CHECKER_MACROS_SVH
`define MODBUS_RTU_REPLY_CHECKER_MACROS_SVH

`ifndef SYNTH

`define MRC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define MRC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MRC_ASSERT_IMP(label, ante, cons, msg)

`define MRC_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

FILE: rtl/mrc_pkg.sv
// shared types, constants and the crc-16 byte update for the modbus rtu reply checker
// no dependencies
`timescale 1ns / 1ps

package mrc_pkg;

  localparam int unsigned MaxDataBytes = 8;
  localparam int unsigned DataIdxW     = $clog2(MaxDataBytes);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [3:0] DataOffset = 4'd3;
  // offset of the trailer high byte for three and four registers
  localparam logic [3:0] FrameLast3 = 4'd10;
  localparam logic [3:0] FrameLast4 = 4'd12;

  localparam logic [2:0] RegCountWide = 3'd4;

  // configuration register indexes
  localparam logic CfgValueCount = 1'b0;
  localparam logic CfgWideValues = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_CRC_ERR  = 2'd1,
    STAT_NO_REPLY = 2'd2
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [31:0] value_first;
    logic [31:0] value_second;
    logic [15:0] value_third;
    logic [15:0] value_fourth;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] r;
    r = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/modbus_rtu_reply_checker.sv
// Modbus RTU read-registers reply checker. Takes one reply byte per cycle while
// the result register is not stalled, and keeps a running reflected CRC-16 over
// the frame. The word with the trailer high byte, or any word flagged read_failed,
// produces one result word with a status and the big-endian register values.
// Bytes pass the input register, then results the result register; throughput is
// one byte per cycle without stall, set by the combinational 8-bit CRC update.
// A result waiting under stall still lets one more byte into the input register.
// depends on mrc_pkg, mrc_frame, mrc_out_reg and the assertion macro header
`timescale 1ns / 1ps
`include "modbus_rtu_reply_checker_macros.svh"

module modbus_rtu_reply_checker import mrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        read_failed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] value_first_o,
  output logic [31:0] value_second_o,
  output logic [15:0] value_third_o,
  output logic [15:0] value_fourth_o
);

  logic       in_valid_q;
  logic [7:0] rx_byte_q;
  logic       read_failed_q;
  logic       out_free;
  logic       step;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign in_stall_o = in_valid_q && !out_free;
  assign step       = in_valid_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      rx_byte_q     <= rx_byte_i;
      read_failed_q <= read_failed_i;
    end
  end

  mrc_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .step_i       (step),
    .rx_byte_i    (rx_byte_q),
    .read_failed_i(read_failed_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  mrc_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .res_i      (res),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (out_res)
  );

  assign status_o       = out_res.status;
  assign value_first_o  = out_res.value_first;
  assign value_second_o = out_res.value_second;
  assign value_third_o  = out_res.value_third;
  assign value_fourth_o = out_res.value_fourth;

  `MRC_ASSERT_NXT(a_in_hold, in_stall_o, in_valid_q && $stable(rx_byte_q) &&
                  $stable(read_failed_q), "stalled input word lost")

endmodule

FILE: rtl/mrc_frame.sv
// frame tracker: config registers, byte position, crc, data bytes and trailer check
// depends on mrc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "modbus_rtu_reply_checker_macros.svh"

module mrc_frame import mrc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [2:0]    cfg_wdata_i,
  input  logic          step_i,
  input  logic [7:0]    rx_byte_i,
  input  logic          read_failed_i,
  output logic          res_valid_o,
  output result_t       res_o
);

  logic [2:0]  value_count_q;
  logic        wide_values_q;
  logic [3:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  data_q [MaxDataBytes];
  logic [7:0]  trailer_low_q;

  logic        four_regs;
  logic [3:0]  last_pos;
  logic        at_end;
  logic        crc_ok;
  logic [3:0]  data_ofs;
  logic        data_wr;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_count_q <= RegCountWide;
      wide_values_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgValueCount: value_count_q <= cfg_wdata_i;
        CfgWideValues: wide_values_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign four_regs = (value_count_q >= RegCountWide);
  assign last_pos  = four_regs ? FrameLast4 : FrameLast3;
  assign at_end    = (pos_q >= last_pos);
  assign crc_ok    = ({rx_byte_i, trailer_low_q} == crc_q);
  assign data_ofs  = pos_q - DataOffset;
  assign data_wr   = step_i && !read_failed_i && !at_end && (pos_q != last_pos - 4'd1) &&
                     (pos_q >= DataOffset) && (data_ofs < 4'(MaxDataBytes));

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    if (step_i) begin
      if (read_failed_i || at_end) begin
        pos_d = '0;
        crc_d = CrcInit;
      end else begin
        pos_d = pos_q + 4'd1;
        if (pos_q != last_pos - 4'd1) begin
          crc_d = crc_byte(crc_q, rx_byte_i);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= CrcInit;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_wr) begin
      data_q[data_ofs[DataIdxW-1:0]] <= rx_byte_i;
    end
    if (step_i && !read_failed_i && !at_end && (pos_q == last_pos - 4'd1)) begin
      trailer_low_q <= rx_byte_i;
    end
  end

  assign res_valid_o = step_i && (read_failed_i || at_end);

  always_comb begin
    res_o = '{status: STAT_NO_REPLY, value_first: '0, value_second: '0,
              value_third: '0, value_fourth: '0};
    if (!read_failed_i) begin
      if (!crc_ok) begin
        res_o.status = STAT_CRC_ERR;
      end else begin
        res_o.status = STAT_OK;
        if (wide_values_q && four_regs) begin
          res_o.value_first  = {data_q[0], data_q[1], data_q[2], data_q[3]};
          res_o.value_second = {data_q[4], data_q[5], data_q[6], data_q[7]};
        end else begin
          res_o.value_first  = {16'h0000, data_q[0], data_q[1]};
          res_o.value_second = {16'h0000, data_q[2], data_q[3]};
          res_o.value_third  = {data_q[4], data_q[5]};
          if (four_regs) begin
            res_o.value_fourth = {data_q[6], data_q[7]};
          end
        end
      end
    end
  end

  `MRC_ASSERT_IMP(a_pos_bound, 1'b1, pos_q <= FrameLast4, "byte position beyond frame end")
  `MRC_ASSERT_NXT(a_fail_restart, step_i && read_failed_i, pos_q == 4'd0 && crc_q == CrcInit,
                  "read failure did not restart the frame")

endmodule

FILE: rtl/mrc_out_reg.sv
// result register: holds one reply word until the downstream side takes it
// depends on mrc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "modbus_rtu_reply_checker_macros.svh"

module mrc_out_reg import mrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  result_t     res_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output result_t     res_o
);

  logic    out_valid_q;
  result_t res_q;

  assign free_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  `MRC_ASSERT_IMP(a_err_zero, out_valid_q && res_q.status != STAT_OK,
                  res_q.value_first == '0 && res_q.value_second == '0 &&
                  res_q.value_third == '0 && res_q.value_fourth == '0,
                  "failed reply carries nonzero values")
  `MRC_ASSERT_IMP(a_load_free, load_i, free_o, "result loaded over a held word")

endmodule
